[src/cbla_pkg.sv]
`default_nettype none
package cbla_pkg;

  // Fraction bits of the unit-vector format.
  localparam int UF = 14;
  localparam int IW = 32;
  localparam int OW = 16;
  // Signed component width at the normalizer input; holds up cross w.
  localparam int CW = UF + 34;
  localparam int MW = CW - 1;
  // Components are scaled below 2^SW before squaring.
  localparam int SW = 30;
  localparam int SHW = $clog2(MW - SW + 1);
  localparam int SQW = 2 * SW + 2;
  localparam int LW = SW + 2;
  localparam int RW = SW + UF + 3;
  localparam int QW = UF + 1;
  localparam int UW = UF + 2;
  localparam int ISQ_STEPS = SW + 1;
  localparam int DIV_STEPS = QW;
  localparam int NORM_LAT = 7 + ISQ_STEPS + DIV_STEPS;

  typedef logic signed [UW-1:0] unit_t;
  localparam unit_t ONE_UNIT = {1'b0, 1'b1, {UF{1'b0}}};

  typedef struct packed {
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] y;
    logic signed [IW-1:0] z;
  } ivec_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cvec_t;

  typedef struct packed {
    unit_t x;
    unit_t y;
    unit_t z;
  } uvec_t;

  typedef struct packed {
    logic look_down;
    logic look_up;
  } view_t;

  // Rounds a product of two unit values back to the unit format,
  // half away from zero, saturated at one.
  function automatic unit_t to_unit(input logic signed [2*UW:0] p);
    logic [2*UW:0] m;
    logic [2*UW:0] t;
    unit_t r;
    m = p[2*UW] ? (2*UW+1)'(-p) : (2*UW+1)'(p);
    t = (m + ((2*UW+1)'(1) << (UF - 1))) >> UF;
    if (t > (2*UW+1)'(ONE_UNIT)) r = ONE_UNIT;
    else r = UW'(t);
    return p[2*UW] ? -r : r;
  endfunction

endpackage
`default_nettype wire

[src/camera_basis_from_look_at.sv]
// Channel  Signals                                        Beat
// in       in_valid, in_ready, eye_*, target_*, upward_*  one look-at query
// out      out_valid, out_ready, axis_u/v/w_*, degenerate one camera basis
//
// A beat is accepted every cycle while the output side keeps taking results.
// Most of the pipeline depth lies in the two normalizers, each a 31-stage
// square root followed by a 15-stage divider.
// Reset clears only the valid bits; payload registers are not reset.
// When the output register holds a beat that is not taken, the whole pipeline
// holds and in_ready is low.
`default_nettype none
module camera_basis_from_look_at (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] upward_x,
  input  logic signed [31:0] upward_y,
  input  logic signed [31:0] upward_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] axis_u_x,
  output logic signed [15:0] axis_u_y,
  output logic signed [15:0] axis_u_z,
  output logic signed [15:0] axis_v_x,
  output logic signed [15:0] axis_v_y,
  output logic signed [15:0] axis_v_z,
  output logic signed [15:0] axis_w_x,
  output logic signed [15:0] axis_w_y,
  output logic signed [15:0] axis_w_z,
  output logic               degenerate
);

  localparam int IW = cbla_pkg::IW;
  localparam int CW = cbla_pkg::CW;
  localparam int UW = cbla_pkg::UW;
  localparam int OW = cbla_pkg::OW;
  localparam int NL = cbla_pkg::NORM_LAT;
  localparam int TOT = 2 * NL + 5;
  localparam int PW = IW + UW;

  typedef struct packed {
    cbla_pkg::ivec_t up;
    cbla_pkg::view_t view;
  } side1_t;

  typedef struct packed {
    cbla_pkg::uvec_t w;
    logic okw;
    cbla_pkg::view_t view;
  } side2_t;

  logic [TOT-1:0] vld;
  logic adv;

  assign adv = !vld[TOT-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  // Entry stage: difference vector and the two vertical-view cases.
  logic signed [IW:0] dx, dy, dz;
  assign dx = (IW+1)'(eye_x) - (IW+1)'(target_x);
  assign dy = (IW+1)'(eye_y) - (IW+1)'(target_y);
  assign dz = (IW+1)'(eye_z) - (IW+1)'(target_z);

  cbla_pkg::cvec_t d0;
  side1_t s0;

  always_ff @(posedge clk) begin
    if (adv) begin
      d0.x <= CW'(dx);
      d0.y <= CW'(dy);
      d0.z <= CW'(dz);
      s0.up.x <= upward_x;
      s0.up.y <= upward_y;
      s0.up.z <= upward_z;
      s0.view.look_down <= (dx == '0) && (dz == '0) && !dy[IW] && (dy != '0);
      s0.view.look_up <= (dx == '0) && (dz == '0) && dy[IW];
    end
  end

  cbla_pkg::uvec_t w_n;
  logic okw_n;

  cbla_norm u_norm_w (
    .clk(clk),
    .en(adv),
    .vec(d0),
    .unit(w_n),
    .nonzero(okw_n)
  );

  side1_t dl1 [NL];
  always_ff @(posedge clk) begin
    if (adv) begin
      dl1[0] <= s0;
      for (int k = 1; k < NL; k++) dl1[k] <= dl1[k-1];
    end
  end

  // up cross w: products, then differences.
  logic signed [PW-1:0] p1 [6];
  side2_t s1, s2;
  cbla_pkg::cvec_t cu2;
  cbla_pkg::ivec_t upd;
  assign upd = dl1[NL-1].up;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1[0] <= PW'(upd.y) * PW'(w_n.z);
      p1[1] <= PW'(upd.z) * PW'(w_n.y);
      p1[2] <= PW'(upd.z) * PW'(w_n.x);
      p1[3] <= PW'(upd.x) * PW'(w_n.z);
      p1[4] <= PW'(upd.x) * PW'(w_n.y);
      p1[5] <= PW'(upd.y) * PW'(w_n.x);
      s1.w <= w_n;
      s1.okw <= okw_n;
      s1.view <= dl1[NL-1].view;
      cu2.x <= CW'(p1[0] - p1[1]);
      cu2.y <= CW'(p1[2] - p1[3]);
      cu2.z <= CW'(p1[4] - p1[5]);
      s2 <= s1;
    end
  end

  cbla_pkg::uvec_t u_n;
  logic oku_n;

  cbla_norm u_norm_u (
    .clk(clk),
    .en(adv),
    .vec(cu2),
    .unit(u_n),
    .nonzero(oku_n)
  );

  side2_t dl2 [NL];
  always_ff @(posedge clk) begin
    if (adv) begin
      dl2[0] <= s2;
      for (int k = 1; k < NL; k++) dl2[k] <= dl2[k-1];
    end
  end

  // w cross u: products, then rounding and the final selection.
  logic signed [2*UW-1:0] p3 [6];
  side2_t s3;
  cbla_pkg::uvec_t u3;
  logic oku3;
  cbla_pkg::uvec_t wd;
  assign wd = dl2[NL-1].w;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3[0] <= wd.y * u_n.z;
      p3[1] <= wd.z * u_n.y;
      p3[2] <= wd.z * u_n.x;
      p3[3] <= wd.x * u_n.z;
      p3[4] <= wd.x * u_n.y;
      p3[5] <= wd.y * u_n.x;
      s3 <= dl2[NL-1];
      u3 <= u_n;
      oku3 <= oku_n;
    end
  end

  cbla_pkg::uvec_t uo, vo, wo, vc;
  logic dg;

  always_comb begin
    vc.x = cbla_pkg::to_unit((2*UW+1)'(p3[0]) - (2*UW+1)'(p3[1]));
    vc.y = cbla_pkg::to_unit((2*UW+1)'(p3[2]) - (2*UW+1)'(p3[3]));
    vc.z = cbla_pkg::to_unit((2*UW+1)'(p3[4]) - (2*UW+1)'(p3[5]));
    uo = '0;
    vo = '0;
    wo = '0;
    dg = 1'b0;
    if (s3.view.look_down) begin
      uo.z = cbla_pkg::ONE_UNIT;
      vo.x = cbla_pkg::ONE_UNIT;
      wo.y = cbla_pkg::ONE_UNIT;
    end else if (s3.view.look_up) begin
      uo.x = cbla_pkg::ONE_UNIT;
      vo.z = cbla_pkg::ONE_UNIT;
      wo.y = -cbla_pkg::ONE_UNIT;
    end else if (!s3.okw || !oku3) begin
      dg = 1'b1;
    end else begin
      uo = u3;
      vo = vc;
      wo = s3.w;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      axis_u_x <= OW'(uo.x);
      axis_u_y <= OW'(uo.y);
      axis_u_z <= OW'(uo.z);
      axis_v_x <= OW'(vo.x);
      axis_v_y <= OW'(vo.y);
      axis_v_z <= OW'(vo.z);
      axis_w_x <= OW'(wo.x);
      axis_w_y <= OW'(wo.y);
      axis_w_z <= OW'(wo.z);
      degenerate <= dg;
    end
  end

endmodule
`default_nettype wire

[src/cbla_norm.sv]
`default_nettype none
module cbla_norm (
  input  logic              clk,
  input  logic              en,
  input  cbla_pkg::cvec_t   vec,
  output cbla_pkg::uvec_t   unit,
  output logic              nonzero
);

  localparam int CW = cbla_pkg::CW;
  localparam int MW = cbla_pkg::MW;
  localparam int SW = cbla_pkg::SW;
  localparam int SHW = cbla_pkg::SHW;
  localparam int SQW = cbla_pkg::SQW;
  localparam int LW = cbla_pkg::LW;
  localparam int RW = cbla_pkg::RW;
  localparam int QW = cbla_pkg::QW;
  localparam int UW = cbla_pkg::UW;
  localparam int UF = cbla_pkg::UF;
  localparam int NI = cbla_pkg::ISQ_STEPS;
  localparam int ND = cbla_pkg::DIV_STEPS;

  logic signed [CW-1:0] cin [3];
  assign cin[0] = vec.x;
  assign cin[1] = vec.y;
  assign cin[2] = vec.z;

  logic [MW-1:0] m1 [3];
  logic [2:0] neg1;
  logic [MW-1:0] m2 [3];
  logic [MW-1:0] mx2;
  logic [2:0] neg2;
  logic [MW-1:0] m3 [3];
  logic [SHW-1:0] s3;
  logic [2:0] neg3;
  logic [SW-1:0] ms4 [3];
  logic [2:0] neg4;
  logic [2*SW-1:0] sq5 [3];
  logic [SW-1:0] ms5 [3];
  logic [2:0] neg5;

  logic [MW-1:0] mx_a;
  logic [MW-1:0] mx_b;
  logic [SHW-1:0] shift;

  always_comb begin
    mx_a = (m1[0] > m1[1]) ? m1[0] : m1[1];
    mx_b = (mx_a > m1[2]) ? mx_a : m1[2];
  end

  // The shift brings the largest magnitude below 2^SW.
  always_comb begin
    shift = '0;
    for (int b = SW; b < MW; b++) begin
      if (mx2[b]) shift = SHW'(b - SW + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i] <= cin[i][CW-1] ? MW'(-cin[i]) : MW'(cin[i]);
        neg1[i] <= cin[i][CW-1];
        m2[i] <= m1[i];
        m3[i] <= m2[i];
        ms4[i] <= SW'(m3[i] >> s3);
        sq5[i] <= ms4[i] * ms4[i];
        ms5[i] <= ms4[i];
      end
      mx2 <= mx_b;
      neg2 <= neg1;
      s3 <= shift;
      neg3 <= neg2;
      neg4 <= neg3;
      neg5 <= neg4;
    end
  end

  // Square root, one result bit per stage.
  logic [SQW-1:0] isq_n [NI+1];
  logic [SQW-1:0] isq_r [NI+1];
  logic [SW-1:0] isq_m [NI+1][3];
  logic [2:0] isq_neg [NI+1];

  always_ff @(posedge clk) begin
    if (en) begin
      isq_n[0] <= SQW'(sq5[0]) + SQW'(sq5[1]) + SQW'(sq5[2]);
      isq_r[0] <= '0;
      isq_m[0] <= ms5;
      isq_neg[0] <= neg5;
    end
  end

  for (genvar k = 1; k <= NI; k++) begin : g_isq
    logic [SQW-1:0] bitv;
    logic [SQW:0] trial;
    assign bitv = SQW'(1) << (2 * (NI - k));
    assign trial = (SQW+1)'(isq_r[k-1]) + (SQW+1)'(bitv);
    always_ff @(posedge clk) begin
      if (en) begin
        if ((SQW+1)'(isq_n[k-1]) >= trial) begin
          isq_n[k] <= isq_n[k-1] - SQW'(trial);
          isq_r[k] <= (isq_r[k-1] >> 1) + bitv;
        end else begin
          isq_n[k] <= isq_n[k-1];
          isq_r[k] <= isq_r[k-1] >> 1;
        end
        isq_m[k] <= isq_m[k-1];
        isq_neg[k] <= isq_neg[k-1];
      end
    end
  end

  // Restoring division of each scaled component by the length.
  logic [LW-1:0] len;
  logic [RW-1:0] dv_rem [ND+1][3];
  logic [QW-1:0] dv_q [ND+1][3];
  logic [LW-1:0] dv_l [ND+1];
  logic [2:0] dv_neg [ND+1];

  assign len = LW'(isq_r[NI]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (RW'(isq_m[NI][i]) << UF) + RW'(len >> 1);
        dv_q[0][i] <= '0;
      end
      dv_l[0] <= len;
      dv_neg[0] <= isq_neg[NI];
    end
  end

  for (genvar j = 1; j <= ND; j++) begin : g_div
    logic [RW-1:0] dsor;
    assign dsor = RW'(dv_l[j-1]) << (ND - j);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j-1][i] >= dsor) begin
            dv_rem[j][i] <= dv_rem[j-1][i] - dsor;
            dv_q[j][i] <= dv_q[j-1][i] | (QW'(1) << (ND - j));
          end else begin
            dv_rem[j][i] <= dv_rem[j-1][i];
            dv_q[j][i] <= dv_q[j-1][i];
          end
        end
        dv_l[j] <= dv_l[j-1];
        dv_neg[j] <= dv_neg[j-1];
      end
    end
  end

  cbla_pkg::unit_t qs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = dv_neg[ND][i] ? -$signed({1'b0, dv_q[ND][i]}) : $signed({1'b0, dv_q[ND][i]});
    end
  end

  assign unit.x = UW'(qs[0]);
  assign unit.y = UW'(qs[1]);
  assign unit.z = UW'(qs[2]);
  assign nonzero = (dv_l[ND] != '0);

endmodule
`default_nettype wire

[src/cbla_chk.sv]
`default_nettype none
module cbla_chk (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] axis_u_x,
  input logic signed [15:0] axis_u_y,
  input logic signed [15:0] axis_u_z,
  input logic signed [15:0] axis_w_x,
  input logic signed [15:0] axis_w_y,
  input logic signed [15:0] axis_w_z,
  input logic               degenerate
);

  // A degenerate frame carries all-zero u and w axes.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> axis_u_x == 16'sd0 && axis_u_y == 16'sd0 &&
      axis_u_z == 16'sd0 && axis_w_x == 16'sd0 && axis_w_y == 16'sd0 &&
      axis_w_z == 16'sd0)
    else $error("degenerate frame with nonzero axes");

  // A good frame has nonzero u and w axes.
  a_good_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |->
      (axis_u_x != 16'sd0 || axis_u_y != 16'sd0 || axis_u_z != 16'sd0) &&
      (axis_w_x != 16'sd0 || axis_w_y != 16'sd0 || axis_w_z != 16'sd0))
    else $error("valid frame with a zero axis");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(axis_w_x) &&
      $stable(degenerate))
    else $error("stalled output beat changed");

endmodule

bind camera_basis_from_look_at cbla_chk u_cbla_chk (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .axis_u_x(axis_u_x),
  .axis_u_y(axis_u_y),
  .axis_u_z(axis_u_z),
  .axis_w_x(axis_w_x),
  .axis_w_y(axis_w_y),
  .axis_w_z(axis_w_z),
  .degenerate(degenerate)
);
`default_nettype wire
